// ===== hdl/lbl_pkg.sv =====
// lbl_pkg: shared constants and types for the spectrum bin log bar level core
// no dependencies; used by every module of the block
`default_nettype none

package lbl_pkg;

  localparam int BINS           = 256;
  localparam int DISPLAY_HEIGHT = 70;
  localparam int DISPLAY_WIDTH  = 480;

  // bins are a power of two: the bin is taken modulo BINS by truncation
  localparam int BIN_W   = $clog2(BINS);
  localparam int IDX_W   = 8;
  localparam int PART_W  = 20;
  localparam int MAG_W   = 20;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  localparam int RATIO_SCALE = 1000;
  localparam int RATIO_W     = $clog2(RATIO_SCALE + 1);
  localparam int NUM_W       = MAG_W + RATIO_W;

  localparam int FRAC_BITS = 16;
  localparam int EXP_W     = $clog2(RATIO_W);
  localparam int L2_W      = EXP_W + FRAC_BITS;
  localparam int MANT_W    = 31;
  localparam int SHIFT_W   = $clog2(MANT_W);

  localparam int LN2_Q16     = 45426;
  localparam int LOG_DIV     = 69;
  localparam int HEIGHT_K    = LN2_Q16 * DISPLAY_HEIGHT * 10;
  localparam int K_W         = $clog2(HEIGHT_K + 1);
  localparam int PROD_W      = L2_W + K_W;
  localparam int PROD_SHIFT  = 32;
  localparam int Q_W         = PROD_W - PROD_SHIFT;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP       = (2 ** RECIP_SHIFT + LOG_DIV - 1) / LOG_DIV;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int CLAMP_Q     = LOG_DIV * DISPLAY_HEIGHT;

  localparam int HEIGHT_W = 7;
  localparam int COL_W    = 9;
  localparam int COLP_W   = BIN_W + 1 + $clog2(DISPLAY_WIDTH + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] peak;
  } item_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             zero;
  } tag_t;

endpackage

`default_nettype wire

// ===== hdl/lbl_front.sv =====
// lbl_front: accepts bins, forms |re|+|im| and updates the per-bin peak store
// depends on lbl_pkg
`default_nettype none

module lbl_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lbl_pkg::IDX_W-1:0]      in_bin,
  input  wire logic signed [lbl_pkg::PART_W-1:0] in_re,
  input  wire logic signed [lbl_pkg::PART_W-1:0] in_im,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output lbl_pkg::item_t                      out_item
);

  logic [lbl_pkg::MAG_W-1:0]  peak_mem [lbl_pkg::BINS];
  logic [lbl_pkg::BINS-1:0]   peak_set;

  logic [lbl_pkg::PART_W-1:0] re_abs;
  logic [lbl_pkg::PART_W-1:0] im_abs;
  logic [lbl_pkg::PART_W:0]   mag_sum;
  logic [lbl_pkg::MAG_W-1:0]  mag_c;
  logic [lbl_pkg::BIN_W-1:0]  bin_c;
  logic                       accept;
  logic                       advance;

  logic                       f_valid;
  logic [lbl_pkg::BIN_W-1:0]  f_bin;
  logic [lbl_pkg::MAG_W-1:0]  f_mag;
  logic [lbl_pkg::MAG_W-1:0]  rd_peak;
  logic                       rd_set;

  logic                       byp_valid;
  logic [lbl_pkg::BIN_W-1:0]  byp_bin;
  logic [lbl_pkg::MAG_W-1:0]  byp_peak;

  logic [lbl_pkg::MAG_W-1:0]  peak_old;
  logic [lbl_pkg::MAG_W-1:0]  peak_new;

  assign re_abs  = in_re[lbl_pkg::PART_W-1] ? (~in_re + 1'b1) : in_re;
  assign im_abs  = in_im[lbl_pkg::PART_W-1] ? (~in_im + 1'b1) : in_im;
  assign mag_sum = {1'b0, re_abs} + {1'b0, im_abs};
  assign mag_c   = mag_sum[lbl_pkg::PART_W] ? lbl_pkg::MAG_MAX : mag_sum[lbl_pkg::MAG_W-1:0];
  assign bin_c   = in_bin[lbl_pkg::BIN_W-1:0];

  assign advance  = f_valid && out_ready;
  assign in_ready = !f_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // last write wins over a read that raced it
  always_comb begin
    if (byp_valid && (byp_bin == f_bin)) begin
      peak_old = byp_peak;
    end else if (rd_set) begin
      peak_old = rd_peak;
    end else begin
      peak_old = '0;
    end
    peak_new = (f_mag > peak_old) ? f_mag : peak_old;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_peak <= peak_mem[bin_c];
    end
    if (advance) begin
      peak_mem[f_bin] <= peak_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_bin  <= bin_c;
      f_mag  <= mag_c;
      rd_set <= peak_set[bin_c];
    end
    if (advance) begin
      byp_bin  <= f_bin;
      byp_peak <= peak_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      byp_valid <= 1'b0;
      peak_set  <= '0;
    end else begin
      if (accept) begin
        f_valid <= 1'b1;
      end else if (advance) begin
        f_valid <= 1'b0;
      end
      if (advance) begin
        byp_valid       <= 1'b1;
        peak_set[f_bin] <= 1'b1;
      end
    end
  end

  assign out_valid = f_valid;
  assign out_item  = '{bin: f_bin, mag: f_mag, peak: peak_new};

endmodule

`default_nettype wire

// ===== hdl/lbl_fifo.sv =====
// lbl_fifo: short queue between the front and back parts
// depends on lbl_pkg
`default_nettype none

module lbl_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire lbl_pkg::item_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output lbl_pkg::item_t      pop_data
);

  lbl_pkg::item_t              slots [lbl_pkg::FIFO_DEPTH];
  logic [lbl_pkg::FIFO_AW-1:0] wr_ptr;
  logic [lbl_pkg::FIFO_AW-1:0] rd_ptr;
  logic [lbl_pkg::FIFO_AW:0]   count;
  logic                        push;
  logic                        pop;

  assign push_ready = (count != (lbl_pkg::FIFO_AW + 1)'(lbl_pkg::FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lbl_div.sv =====
// lbl_div: pipelined restoring divider, one quotient bit per stage
// depends on lbl_pkg
`default_nettype none

module lbl_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [lbl_pkg::NUM_W-1:0]      in_num,
  input  wire logic [lbl_pkg::MAG_W-1:0]      in_den,
  input  wire lbl_pkg::tag_t                  in_tag,
  output logic                                out_valid,
  output logic [lbl_pkg::RATIO_W-1:0]         out_quot,
  output lbl_pkg::tag_t                       out_tag
);

  localparam int STEPS = lbl_pkg::RATIO_W;

  logic                         v_a   [STEPS+1];
  logic [lbl_pkg::NUM_W-1:0]    rem_a [STEPS+1];
  logic [lbl_pkg::MAG_W-1:0]    den_a [STEPS+1];
  logic [lbl_pkg::RATIO_W-1:0]  quo_a [STEPS+1];
  lbl_pkg::tag_t                tag_a [STEPS+1];

  assign v_a[0]   = in_valid;
  assign rem_a[0] = in_num;
  assign den_a[0] = in_den;
  assign quo_a[0] = '0;
  assign tag_a[0] = in_tag;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int SH = STEPS - 1 - k;
    logic [lbl_pkg::NUM_W-1:0] trial;
    logic                      take;

    assign trial = lbl_pkg::NUM_W'(den_a[k]) << SH;
    assign take  = (rem_a[k] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[k+1] <= 1'b0;
      end else if (en) begin
        v_a[k+1] <= v_a[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[k+1] <= take ? (rem_a[k] - trial) : rem_a[k];
        den_a[k+1] <= den_a[k];
        quo_a[k+1] <= {quo_a[k][lbl_pkg::RATIO_W-2:0], take};
        tag_a[k+1] <= tag_a[k];
      end
    end
  end

  assign out_valid = v_a[STEPS];
  assign out_quot  = quo_a[STEPS];
  assign out_tag   = tag_a[STEPS];

endmodule

`default_nettype wire

// ===== hdl/lbl_log.sv =====
// lbl_log: pipelined log2 in q16, normalise stage then one squaring per stage
// depends on lbl_pkg
`default_nettype none

module lbl_log (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [lbl_pkg::RATIO_W-1:0]    in_r,
  input  wire lbl_pkg::tag_t                  in_tag,
  output logic                                out_valid,
  output logic [lbl_pkg::L2_W-1:0]            out_l2,
  output lbl_pkg::tag_t                       out_tag
);

  localparam int STEPS = lbl_pkg::FRAC_BITS;
  localparam int MW    = lbl_pkg::MANT_W;

  logic [lbl_pkg::EXP_W-1:0]     n_c;
  logic [lbl_pkg::SHIFT_W-1:0]   sh_c;

  logic                          v_a    [STEPS+1];
  logic [MW-1:0]                 mant_a [STEPS+1];
  logic [lbl_pkg::EXP_W-1:0]     exp_a  [STEPS+1];
  logic [lbl_pkg::FRAC_BITS-1:0] frac_a [STEPS+1];
  lbl_pkg::tag_t                 tag_a  [STEPS+1];

  always_comb begin
    n_c = '0;
    for (int i = 0; i < lbl_pkg::RATIO_W; i++) begin
      if (in_r[i]) begin
        n_c = lbl_pkg::EXP_W'(i);
      end
    end
  end

  assign sh_c = lbl_pkg::SHIFT_W'(MW - 1) - lbl_pkg::SHIFT_W'(n_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a[0] <= 1'b0;
    end else if (en) begin
      v_a[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mant_a[0] <= MW'(in_r) << sh_c;
      exp_a[0]  <= n_c;
      frac_a[0] <= '0;
      tag_a[0]  <= '{bin: in_tag.bin, zero: in_tag.zero || (in_r == '0)};
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     t;

    assign sq = (2*MW)'(mant_a[k]) * (2*MW)'(mant_a[k]);
    assign t  = sq[2*MW-1:MW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[k+1] <= 1'b0;
      end else if (en) begin
        v_a[k+1] <= v_a[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mant_a[k+1] <= t[MW] ? t[MW:1] : t[MW-1:0];
        frac_a[k+1] <= {frac_a[k][lbl_pkg::FRAC_BITS-2:0], t[MW]};
        exp_a[k+1]  <= exp_a[k];
        tag_a[k+1]  <= tag_a[k];
      end
    end
  end

  assign out_valid = v_a[STEPS];
  assign out_l2    = {exp_a[STEPS], frac_a[STEPS]};
  assign out_tag   = tag_a[STEPS];

endmodule

`default_nettype wire

// ===== hdl/lbl_back.sv =====
// lbl_back: ratio, log, height scaling and the output register
// depends on lbl_pkg, lbl_div, lbl_log
`default_nettype none

module lbl_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire lbl_pkg::item_t                in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lbl_pkg::HEIGHT_W-1:0]       out_bar_height,
  output logic [lbl_pkg::HEIGHT_W-1:0]       out_top_row,
  output logic [lbl_pkg::COL_W-1:0]          out_column_first,
  output logic [lbl_pkg::COL_W-1:0]          out_column_end
);

  logic                                en;

  logic                                a_valid;
  logic [lbl_pkg::NUM_W-1:0]           a_num;
  logic [lbl_pkg::MAG_W-1:0]           a_den;
  lbl_pkg::tag_t                       a_tag;

  logic                                d_valid;
  logic [lbl_pkg::RATIO_W-1:0]         d_quot;
  lbl_pkg::tag_t                       d_tag;

  logic                                l_valid;
  logic [lbl_pkg::L2_W-1:0]            l_l2;
  lbl_pkg::tag_t                       l_tag;

  logic [lbl_pkg::PROD_W-1:0]          prod_c;
  logic                                s_valid;
  logic [lbl_pkg::Q_W-1:0]             s_q;
  lbl_pkg::tag_t                       s_tag;

  logic [lbl_pkg::Q_W+lbl_pkg::RECIP_W-1:0] recip_c;
  logic [lbl_pkg::HEIGHT_W-1:0]        height_c;
  logic [lbl_pkg::COLP_W-1:0]          first_p;
  logic [lbl_pkg::COLP_W-1:0]          end_p;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_num <= lbl_pkg::NUM_W'(in_item.mag) * lbl_pkg::NUM_W'(lbl_pkg::RATIO_SCALE);
      a_den <= in_item.peak;
      a_tag <= '{bin: in_item.bin, zero: (in_item.peak == '0)};
    end
  end

  lbl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (a_valid),
    .in_num   (a_num),
    .in_den   (a_den),
    .in_tag   (a_tag),
    .out_valid(d_valid),
    .out_quot (d_quot),
    .out_tag  (d_tag)
  );

  lbl_log u_log (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_valid),
    .in_r     (d_quot),
    .in_tag   (d_tag),
    .out_valid(l_valid),
    .out_l2   (l_l2),
    .out_tag  (l_tag)
  );

  // ln2 * height * 10 / 69, the /69 finished after the shift
  assign prod_c = lbl_pkg::PROD_W'(l_l2) * lbl_pkg::PROD_W'(lbl_pkg::HEIGHT_K);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (en) begin
      s_valid <= l_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_q   <= prod_c[lbl_pkg::PROD_W-1:lbl_pkg::PROD_SHIFT];
      s_tag <= l_tag;
    end
  end

  assign recip_c = (lbl_pkg::Q_W + lbl_pkg::RECIP_W)'(s_q)
                 * (lbl_pkg::Q_W + lbl_pkg::RECIP_W)'(lbl_pkg::RECIP);

  always_comb begin
    if (s_tag.zero) begin
      height_c = '0;
    end else if (32'(s_q) >= 32'(lbl_pkg::CLAMP_Q)) begin
      height_c = lbl_pkg::HEIGHT_W'(lbl_pkg::DISPLAY_HEIGHT);
    end else begin
      height_c = lbl_pkg::HEIGHT_W'(recip_c >> lbl_pkg::RECIP_SHIFT);
    end
  end

  assign first_p = (lbl_pkg::COLP_W'(s_tag.bin) * lbl_pkg::COLP_W'(lbl_pkg::DISPLAY_WIDTH))
                   >> lbl_pkg::BIN_W;
  assign end_p   = ((lbl_pkg::COLP_W'(s_tag.bin) + 1'b1)
                   * lbl_pkg::COLP_W'(lbl_pkg::DISPLAY_WIDTH)) >> lbl_pkg::BIN_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bar_height   <= height_c;
      out_top_row      <= lbl_pkg::HEIGHT_W'(lbl_pkg::DISPLAY_HEIGHT) - height_c;
      out_column_first <= first_p[lbl_pkg::COL_W-1:0];
      out_column_end   <= end_p[lbl_pkg::COL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spectrum_bin_log_bar_level_core.sv =====
// spectrum_bin_log_bar_level_core: top level of the spectrum bar level block
// depends on lbl_pkg, lbl_front, lbl_fifo, lbl_back
//
// channel   dir  width  contents (low bit first)
// s_axis    in   48     bin_index[7:0], real_part[27:8], imag_part[47:28]
// m_axis    out  32     bar_height[6:0], top_row[13:7], column_first[22:14],
//                       column_end[31:23]
//
// one bin per clock unless a stalled m_axis fills the queue
// the peak store is read when a bin is taken and written when it moves on,
// with a bypass of the last write so runs of the same bin keep full rate
// reset clears the peak valid flags at once; no clearing pass
// a stalled m_axis holds the back pipeline; the front runs on into the queue
`default_nettype none

module spectrum_bin_log_bar_level_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // bin_index, real_part, imag_part
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // bar_height, top_row, column_first, column_end
);

  logic           q_push_valid;
  logic           q_push_ready;
  lbl_pkg::item_t q_push_data;
  logic           q_pop_valid;
  logic           q_pop_ready;
  lbl_pkg::item_t q_pop_data;

  logic [lbl_pkg::HEIGHT_W-1:0] bar_height;
  logic [lbl_pkg::HEIGHT_W-1:0] top_row;
  logic [lbl_pkg::COL_W-1:0]    column_first;
  logic [lbl_pkg::COL_W-1:0]    column_end;

  lbl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_bin   (s_axis_tdata[7:0]),
    .in_re    (s_axis_tdata[27:8]),
    .in_im    (s_axis_tdata[47:28]),
    .out_valid(q_push_valid),
    .out_ready(q_push_ready),
    .out_item (q_push_data)
  );

  lbl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_data (q_push_data),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data)
  );

  lbl_back u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (q_pop_valid),
    .in_ready        (q_pop_ready),
    .in_item         (q_pop_data),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_bar_height  (bar_height),
    .out_top_row     (top_row),
    .out_column_first(column_first),
    .out_column_end  (column_end)
  );

  assign m_axis_tdata = {column_end, column_first, top_row, bar_height};

endmodule

`default_nettype wire

// ===== hdl/lbl_checker.sv =====
// lbl_checker: port-level assertions for the spectrum bar level core
// depends on lbl_pkg; bound to spectrum_bin_log_bar_level_core
`default_nettype none

module lbl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [47:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  logic [7:0] row_sum;

  assign row_sum = {1'b0, m_axis_tdata[6:0]} + {1'b0, m_axis_tdata[13:7]};

  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a waiting input transfer is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input changed while stalled");

  a_rows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> row_sum == 8'(lbl_pkg::DISPLAY_HEIGHT))
    else $error("bar height and top row disagree");

  a_cols: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:23] > m_axis_tdata[22:14])
    else $error("empty column span");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind spectrum_bin_log_bar_level_core lbl_checker u_lbl_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
